>>> hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, plane and box records and cell control codes for the
// box culling block.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int MAX_PLANES = 8;
  localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CNT_W      = $clog2(MAX_PLANES + 1);

  localparam int NRM_W  = 18;
  localparam int CRD_W  = 40;
  localparam int LIM_W  = 39;
  localparam int PROD_W = NRM_W + CRD_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 39'd25600000000;

  typedef struct packed {
    logic [NRM_W-1:0] nx;
    logic [NRM_W-1:0] ny;
    logic [NRM_W-1:0] nz;
    logic [CRD_W-1:0] offset;
  } plane_t;

  typedef struct packed {
    logic [CRD_W-1:0] min_x;
    logic [CRD_W-1:0] min_y;
    logic [CRD_W-1:0] min_z;
    logic [CRD_W-1:0] max_x;
    logic [CRD_W-1:0] max_y;
    logic [CRD_W-1:0] max_z;
  } box_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    logic clear;
    logic live;
  } dot_ctrl_t;

endpackage

>>> hw/rtl/frustum_box_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_top
// Clip-plane culling of axis-aligned boxes against a ring of plane cells.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | req_type, normals, offset, box
//   out     | output    | out_valid_o/out_stall_i | visible, bounds_ok
//   cfg     | input     | cfg_we_i                | coord_limit
//
// clear and append requests leave the block idle, ready for the next request.
// a box test holds in_stall_o until its result is registered: the plane ring
// rotates once past the shared three-multiplier evaluator, then its pipeline drains.
// the result register frees the input side while a result waits.
// reset empties the plane list and loads the default coordinate limit.
// ----------------------------------------------------------------------------
module frustum_box_cull_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fbc_pkg::LIM_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic signed [fbc_pkg::NRM_W-1:0] normal_x_i,
  input  logic signed [fbc_pkg::NRM_W-1:0] normal_y_i,
  input  logic signed [fbc_pkg::NRM_W-1:0] normal_z_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] plane_offset_i,
  input  logic                       box_valid_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] min_x_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] min_y_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] min_z_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] max_x_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] max_y_i,
  input  logic signed [fbc_pkg::CRD_W-1:0] max_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       visible_o,
  output logic                       bounds_ok_o
);
  import fbc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEST   = 2'd2
  } req_e;

  localparam logic [IDX_W-1:0] RUN_LAST   = IDX_W'(MAX_PLANES - 1);
  localparam logic [IDX_W-1:0] DRAIN_LAST = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_PLANES);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             visible_q, visible_d;
  logic             bounds_q, bounds_d;
  logic [LIM_W-1:0] limit_q;

  box_t             box_q;
  logic             box_valid_q;
  logic             accept, is_append, is_test;
  logic             bounds_ok, ordered, in_range, fail;
  logic [CRD_W-1:0] coord [6];
  logic [CRD_W-1:0] mag   [6];
  cell_op_e         cell_op;
  dot_ctrl_t        dot_ctrl;
  plane_t           new_plane;
  plane_t           cells [MAX_PLANES];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_append  = (req_type_i == REQ_APPEND);
  assign is_test    = (req_type_i == REQ_TEST);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // box capture
  always_ff @(posedge clk_i) begin
    if (accept && is_test) begin
      box_q.min_x <= min_x_i;
      box_q.min_y <= min_y_i;
      box_q.min_z <= min_z_i;
      box_q.max_x <= max_x_i;
      box_q.max_y <= max_y_i;
      box_q.max_z <= max_z_i;
      box_valid_q <= box_valid_i;
    end
  end

  // bounds checks
  assign coord[0] = box_q.min_x;
  assign coord[1] = box_q.min_y;
  assign coord[2] = box_q.min_z;
  assign coord[3] = box_q.max_x;
  assign coord[4] = box_q.max_y;
  assign coord[5] = box_q.max_z;

  always_comb begin
    in_range = 1'b1;
    for (int k = 0; k < 6; k++) begin
      mag[k] = coord[k][CRD_W-1] ? (~coord[k] + CRD_W'(1)) : coord[k];
      if (mag[k] > {1'b0, limit_q}) begin
        in_range = 1'b0;
      end
    end
  end

  assign ordered = ($signed(box_q.min_x) <= $signed(box_q.max_x))
                && ($signed(box_q.min_y) <= $signed(box_q.max_y))
                && ($signed(box_q.min_z) <= $signed(box_q.max_z));
  assign bounds_ok = box_valid_q && ordered && in_range;

  // plane ring
  assign new_plane.nx     = normal_x_i;
  assign new_plane.ny     = normal_y_i;
  assign new_plane.nz     = normal_z_i;
  assign new_plane.offset = plane_offset_i;

  always_comb begin
    if (state_q == ST_RUN) begin
      cell_op = CELL_ROTATE;
    end else if (accept && is_append && (count_q < CNT_FULL)) begin
      cell_op = CELL_SHIFT;
    end else begin
      cell_op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    fbc_plane_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .prev_i  ((i == 0) ? new_plane : cells[(i + MAX_PLANES - 1) % MAX_PLANES]),
      .next_i  (cells[(i + 1) % MAX_PLANES]),
      .plane_o (cells[i])
    );
  end

  assign dot_ctrl.clear = accept && is_test;
  assign dot_ctrl.live  = (state_q == ST_RUN) && ({{(CNT_W-IDX_W){1'b0}}, step_q} < count_q);

  fbc_dot_unit u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dot_ctrl),
    .plane_i (cells[0]),
    .box_i   (box_q),
    .fail_o  (fail)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    visible_d   = visible_q;
    bounds_d    = bounds_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_CLEAR:  count_d = '0;
            REQ_APPEND: begin
              if (count_q < CNT_FULL) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_TEST: begin
              state_d = ST_RUN;
              step_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (step_q == RUN_LAST) begin
          state_d = ST_DRAIN;
          step_d  = '0;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (step_q == DRAIN_LAST) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          visible_d   = bounds_ok && !fail;
          bounds_d    = bounds_ok;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
      bounds_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      visible_q   <= visible_d;
      bounds_q    <= bounds_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;
  assign bounds_ok_o = bounds_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("plane count above store depth");

  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("plane count moved without a request");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == RUN_LAST) |=> state_q == ST_DRAIN)
    else $error("ring rotation did not end after a full turn");

  a_vis_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!visible_o || bounds_ok_o))
    else $error("visible without bounds ok");

endmodule

>>> hw/rtl/fbc_plane_cell.sv
// ----------------------------------------------------------------------------
// fbc_plane_cell
// One plane slot of the plane ring: holds, takes the lower neighbor on an
// append, or takes the upper neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module fbc_plane_cell (
  input  logic              clk_i,
  input  fbc_pkg::cell_op_e op_i,
  input  fbc_pkg::plane_t   prev_i,
  input  fbc_pkg::plane_t   next_i,
  output fbc_pkg::plane_t   plane_o
);
  import fbc_pkg::*;

  plane_t plane_q, plane_d;

  always_comb begin
    case (op_i)
      CELL_SHIFT:  plane_d = prev_i;
      CELL_ROTATE: plane_d = next_i;
      default:     plane_d = plane_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
  end

  assign plane_o = plane_q;

endmodule

>>> hw/rtl/fbc_dot_unit.sv
// ----------------------------------------------------------------------------
// fbc_dot_unit
// Three-stage plane evaluator: p-vertex select and three multiplies, pair
// sums, final sum and sign; keeps a sticky fail flag per box.
// ----------------------------------------------------------------------------
module fbc_dot_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbc_pkg::dot_ctrl_t ctrl_i,
  input  fbc_pkg::plane_t    plane_i,
  input  fbc_pkg::box_t      box_i,
  output logic               fail_o
);
  import fbc_pkg::*;

  logic signed [NRM_W-1:0]  nrm   [3];
  logic signed [CRD_W-1:0]  crn   [3];
  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [SUM_W-1:0]  offs_d, offs_q;
  logic signed [SUM_W-1:0]  s01_d, s01_q, s23_d, s23_q, dsum;
  logic                     v1_q, v2_q, fail_q;

  assign nrm[0] = plane_i.nx;
  assign nrm[1] = plane_i.ny;
  assign nrm[2] = plane_i.nz;

  // p-vertex: max corner for a non-negative normal component
  assign crn[0] = nrm[0][NRM_W-1] ? box_i.min_x : box_i.max_x;
  assign crn[1] = nrm[1][NRM_W-1] ? box_i.min_y : box_i.max_y;
  assign crn[2] = nrm[2][NRM_W-1] ? box_i.min_z : box_i.max_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = nrm[k] * crn[k];
    end
  end

  assign offs_d = {{(SUM_W-CRD_W-16){plane_i.offset[CRD_W-1]}}, plane_i.offset, 16'h0000};

  assign s01_d = {{(SUM_W-PROD_W){prod_q[0][PROD_W-1]}}, prod_q[0]}
               + {{(SUM_W-PROD_W){prod_q[1][PROD_W-1]}}, prod_q[1]};
  assign s23_d = {{(SUM_W-PROD_W){prod_q[2][PROD_W-1]}}, prod_q[2]} + offs_q;
  assign dsum  = s01_q + s23_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    offs_q <= offs_d;
    s01_q  <= s01_d;
    s23_q  <= s23_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      fail_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.live;
      v2_q <= v1_q;
      if (ctrl_i.clear) begin
        fail_q <= 1'b0;
      end else if (v2_q && dsum[SUM_W-1]) begin
        fail_q <= 1'b1;
      end
    end
  end

  assign fail_o = fail_q;

endmodule

>>> tb/tb_frustum_box_cull_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_box_cull_top
// Self-checking bench for the box culling block. Requests clear the plane
// list, append planes or test boxes; a scoreboard keeps its own plane list
// and coordinate limit, predicts visible and bounds_ok for every accepted
// box test and checks results in order. Both channels idle at random, and
// the coordinate limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {
  REQ_CLEAR,
  REQ_APPEND,
  REQ_TEST,
  REQ_RESERVED
} req_e;

typedef struct {
  req_e                           kind;
  logic signed [fbc_pkg::NRM_W-1:0] nrm [3];
  logic signed [fbc_pkg::CRD_W-1:0] offset;
  logic                           box_ok;
  logic signed [fbc_pkg::CRD_W-1:0] lo [3];
  logic signed [fbc_pkg::CRD_W-1:0] hi [3];
} request_t;

typedef struct packed {
  logic visible;
  logic bounds_ok;
} verdict_t;

class cull_scoreboard;
  longint                    nrm_store [fbc_pkg::MAX_PLANES][3];
  longint                    off_store [fbc_pkg::MAX_PLANES];
  int unsigned               plane_count;
  logic [fbc_pkg::LIM_W-1:0] limit;
  verdict_t                  verdicts_due [$];
  int unsigned               errors;
  int unsigned               results_seen;

  function new();
    plane_count  = 0;
    limit        = fbc_pkg::LIMIT_RESET;
    errors       = 0;
    results_seen = 0;
  endfunction

  function bit in_limit(longint c);
    longint mag;
    mag = (c < 0) ? -c : c;
    return mag <= longint'(limit);
  endfunction

  // returns 0 when the block ignores the request
  function bit note_request(request_t r);
    verdict_t v;
    longint   d;
    longint   n;
    int       k;
    int       p;
    case (r.kind)
      REQ_CLEAR: begin
        plane_count = 0;
        return 1'b1;
      end
      REQ_APPEND: begin
        if (plane_count >= fbc_pkg::MAX_PLANES) return 1'b0;
        for (k = 0; k < 3; k++) nrm_store[plane_count][k] = longint'(r.nrm[k]);
        off_store[plane_count] = longint'(r.offset);
        plane_count++;
        return 1'b1;
      end
      REQ_TEST: begin
        v.bounds_ok = r.box_ok;
        for (k = 0; k < 3; k++) begin
          if (r.lo[k] > r.hi[k] || !in_limit(longint'(r.lo[k])) ||
              !in_limit(longint'(r.hi[k]))) begin
            v.bounds_ok = 1'b0;
          end
        end
        v.visible = v.bounds_ok;
        for (p = 0; p < plane_count; p++) begin
          d = off_store[p] * 65536;
          for (k = 0; k < 3; k++) begin
            n = nrm_store[p][k];
            d += n * ((n >= 0) ? longint'(r.hi[k]) : longint'(r.lo[k]));
          end
          if (d < 0) v.visible = 1'b0;
        end
        verdicts_due.push_back(v);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void check_result(logic visible, logic bounds_ok);
    verdict_t v;
    results_seen++;
    if (verdicts_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d with no box test pending: visible=%0d bounds_ok=%0d",
                 results_seen, visible, bounds_ok);
      end
      return;
    end
    v = verdicts_due.pop_front();
    if (visible !== v.visible || bounds_ok !== v.bounds_ok) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d: expected visible=%0d bounds_ok=%0d, got visible=%0d bounds_ok=%0d",
                 results_seen, v.visible, v.bounds_ok, visible, bounds_ok);
      end
    end
  endfunction
endclass

module tb_frustum_box_cull_top;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = fbc_pkg::MAX_PLANES + 12;
  localparam int     PHASE_ITEMS  = 255;
  localparam longint CRD_MAX      = (longint'(1) << 39) - 1;
  localparam longint CRD_MIN      = -(longint'(1) << 39);

  logic                              clk_i;
  logic                              rst_ni       = 1'b0;
  logic                              cfg_we_i     = 1'b0;
  logic [fbc_pkg::LIM_W-1:0]         cfg_data_i   = '0;
  logic                              in_valid_i   = 1'b0;
  logic                              in_stall_o;
  logic [1:0]                        req_type_i   = '0;
  logic signed [fbc_pkg::NRM_W-1:0]  normal_x_i   = '0;
  logic signed [fbc_pkg::NRM_W-1:0]  normal_y_i   = '0;
  logic signed [fbc_pkg::NRM_W-1:0]  normal_z_i   = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  plane_offset_i = '0;
  logic                              box_valid_i  = 1'b0;
  logic signed [fbc_pkg::CRD_W-1:0]  min_x_i      = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  min_y_i      = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  min_z_i      = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  max_x_i      = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  max_y_i      = '0;
  logic signed [fbc_pkg::CRD_W-1:0]  max_z_i      = '0;
  logic                              out_valid_o;
  logic                              out_stall_i  = 1'b0;
  logic                              visible_o;
  logic                              bounds_ok_o;

  cull_scoreboard sb;
  bit             calm;
  int unsigned    issued;

  frustum_box_cull_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .box_valid_i    (box_valid_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .visible_o      (visible_o),
    .bounds_ok_o    (bounds_ok_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic longint rand_within(longint span);
    longint unsigned w;
    longint unsigned m;
    if (span <= 0) return 0;
    w = {$urandom, $urandom};
    m = 2 * span + 1;
    return longint'(w % m) - span;
  endfunction

  function automatic request_t random_request(req_e kind);
    request_t    r;
    logic [63:0] w;
    int          k;
    w         = {$urandom, $urandom};
    r.kind    = kind;
    r.nrm[0]  = w[17:0];
    r.nrm[1]  = w[35:18];
    r.nrm[2]  = w[53:36];
    r.offset  = rand40();
    r.box_ok  = 1'($urandom_range(0, 1));
    for (k = 0; k < 3; k++) begin
      r.lo[k] = rand40();
      r.hi[k] = rand40();
    end
    return r;
  endfunction

  function automatic request_t plane_req(longint nx, longint ny, longint nz, longint off);
    request_t r;
    r        = random_request(REQ_APPEND);
    r.nrm[0] = 18'(nx);
    r.nrm[1] = 18'(ny);
    r.nrm[2] = 18'(nz);
    r.offset = 40'(off);
    return r;
  endfunction

  function automatic request_t box_req(bit ok, longint lx, longint ly, longint lz,
                                       longint hx, longint hy, longint hz);
    request_t r;
    r        = random_request(REQ_TEST);
    r.box_ok = ok;
    r.lo[0]  = 40'(lx);
    r.lo[1]  = 40'(ly);
    r.lo[2]  = 40'(lz);
    r.hi[0]  = 40'(hx);
    r.hi[1]  = 40'(hy);
    r.hi[2]  = 40'(hz);
    return r;
  endfunction

  function automatic request_t random_plane();
    request_t r;
    longint   o;
    int       k;
    r = random_request(REQ_APPEND);
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(0, 6))
        0: r.nrm[k] = '0;
        1: r.nrm[k] = 18'sh1FFFF;
        2: r.nrm[k] = 18'sh20000;
        default: ;
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      o = rand_within(longint'(sb.limit));
      if (o < 0 && $urandom_range(0, 3) != 0) o = -o;
      r.offset = 40'(o);
    end
    return r;
  endfunction

  function automatic request_t random_box();
    request_t r;
    longint   span;
    longint   a;
    longint   b;
    int       k;
    r        = random_request(REQ_TEST);
    r.box_ok = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 7) == 0) return r;
    span = longint'(sb.limit) >> $urandom_range(0, 38);
    for (k = 0; k < 3; k++) begin
      a = rand_within(span);
      b = rand_within(span);
      if ($urandom_range(0, 19) == 0) a = -longint'(sb.limit);
      if ($urandom_range(0, 19) == 0) b = longint'(sb.limit);
      if ($urandom_range(0, 39) == 0) b = longint'(sb.limit) + 1;
      if ((a > b) == ($urandom_range(0, 24) != 0)) begin
        r.lo[k] = 40'(b);
        r.hi[k] = 40'(a);
      end else begin
        r.lo[k] = 40'(a);
        r.hi[k] = 40'(b);
      end
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= r.kind;
    normal_x_i     <= r.nrm[0];
    normal_y_i     <= r.nrm[1];
    normal_z_i     <= r.nrm[2];
    plane_offset_i <= r.offset;
    box_valid_i    <= r.box_ok;
    min_x_i        <= r.lo[0];
    min_y_i        <= r.lo[1];
    min_z_i        <= r.lo[2];
    max_x_i        <= r.hi[0];
    max_y_i        <= r.hi[1];
    max_z_i        <= r.hi[2];
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.note_request(r));
    issued++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [fbc_pkg::LIM_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.limit    = value;
  endtask

  task automatic run_phase();
    int unsigned stop;
    int          i;
    stop = issued + PHASE_ITEMS;
    while (issued < stop) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_request(random_request(req_e'($urandom_range(0, 3))));
      end else begin
        if ($urandom_range(0, 3) != 0) send_request(random_request(REQ_CLEAR));
        for (i = $urandom_range(0, 10); i > 0; i--) send_request(random_plane());
        for (i = $urandom_range(1, 6); i > 0; i--) send_request(random_box());
      end
      if ($urandom_range(0, 60) == 0) drain_results();
    end
  endtask

  // result side
  initial begin
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(visible_o, bounds_ok_o);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("frustum_box_cull_top: mismatch");
    $finish;
  end

  initial begin
    longint                    lim;
    logic [fbc_pkg::LIM_W-1:0] limits [5];
    logic [63:0]               w;
    int                        i;
    sb     = new();
    calm   = 1'b0;
    issued = 0;
    w      = {$urandom, $urandom};
    limits = '{'0, '1, 39'd2560, w[38:0], fbc_pkg::LIMIT_RESET};
    lim    = longint'(fbc_pkg::LIMIT_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, bounds checks
    send_request(box_req(1'b1, 0, 0, 0, 256, 256, 256));
    send_request(box_req(1'b0, 0, 0, 0, 256, 256, 256));
    send_request(box_req(1'b1, 512, 0, 0, 256, 256, 256));
    send_request(box_req(1'b1, -lim, -lim, -lim, lim, lim, lim));
    send_request(box_req(1'b1, 0, 0, -(lim + 1), 0, 0, 0));
    send_request(box_req(1'b1, CRD_MIN, 0, 0, CRD_MAX, 0, 0));
    send_request(random_request(REQ_RESERVED));
    // plane edge: distance exactly zero, then just below
    send_request(plane_req(65536, 0, 0, 0));
    send_request(box_req(1'b1, -256, 0, 0, 0, 5, 5));
    send_request(box_req(1'b1, -2, 0, 0, -1, 0, 0));
    send_request(plane_req(-131072, 131071, 0, CRD_MAX));
    send_request(box_req(1'b1, -lim, -lim, -lim, lim, lim, lim));
    send_request(plane_req(0, 0, -131072, CRD_MIN));
    send_request(box_req(1'b1, -lim, -lim, -lim, lim, lim, lim));
    // fill the store past its end
    send_request(random_request(REQ_CLEAR));
    for (i = 1; i <= fbc_pkg::MAX_PLANES + 1; i++) begin
      send_request(plane_req(longint'(i) * 4096, -longint'(i) * 4096, 65536,
                             256 * longint'(i)));
    end
    send_request(box_req(1'b1, -1000, -1000, -1000, 1000, 1000, 1000));

    run_phase();
    for (i = 0; i < 5; i++) begin
      drain_results();
      write_limit(limits[i]);
      run_phase();
    end
    drain_results();

    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("frustum_box_cull_top: match");
    end else begin
      $display("frustum_box_cull_top: mismatch");
    end
    $finish;
  end

endmodule

>>> frustum_box_cull_top.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_plane_cell.sv
hw/rtl/fbc_dot_unit.sv
hw/rtl/frustum_box_cull_top.sv
tb/tb_frustum_box_cull_top.sv
